/* sv/tsr_pkg.sv */
package tsr_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_EDGE  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam int OUT_ROW_BITS = 10;

    typedef struct packed {
        logic div_start;
        logic walk_load;
        logic walk_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic walk_last;
        logic edge_valid;
    } t_dp_sts;

endpackage

/* sv/triangle_span_rasterizer_core.sv */
// Channel | Signals                          | Direction
// in      | i_valid / o_ready, command fields | into block
// out     | o_valid / i_ready, span fields    | out of block
// A span write is stored when it is accepted. A span read sets r_rd_pend, then r_valid, and
// its result is presented; a new request is taken once that result has been taken.
// A walked edge runs through setup, a serial divider that gives one quotient bit a cycle, and a
// load; then one row is stepped per cycle and written if it lies in the store. A triangle walks edges AC, AB and BC.
// Reset clears control state and the edge-walk registers only; the span store is undefined until written.
// A read result waits in the output register; a new request is taken once it is free.
module triangle_span_rasterizer_core
    import tsr_pkg::*;
#(
    parameter int HEIGHT     = 1024,
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_opcode,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by_coord,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic                         i_side_sel,
    input  logic signed [COORD_BITS-1:0] i_row,
    input  logic signed [COORD_BITS-1:0] i_left_x,
    input  logic signed [COORD_BITS-1:0] i_right_x,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [OUT_ROW_BITS-1:0]      o_out_row,
    output logic signed [COORD_BITS-1:0] o_out_left,
    output logic signed [COORD_BITS-1:0] o_out_right,
    output logic                         o_out_empty
);

    localparam int AW = $clog2(HEIGHT);

    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [COORD_BITS-1:0] w_walk_row, w_walk_x;
    logic signed [COORD_BITS-1:0] r_left_mem  [HEIGHT];
    logic signed [COORD_BITS-1:0] r_right_mem [HEIGHT];
    logic signed [COORD_BITS-1:0] r_rd_l, r_rd_r;
    logic [OUT_ROW_BITS-1:0]      r_rd_row;
    logic                         r_rd_pend;
    logic                         r_valid;
    logic                         w_acc, w_busy, w_we, w_wside, w_row_ok, w_walk_ok;
    logic [1:0]                   w_esel;
    t_dp_cmd                      w_cmd;
    t_dp_sts                      w_sts;
    logic                         r_is_tri;
    logic signed [COORD_BITS-1:0] w_sx0, w_sy0, w_sx1, w_sy1;

    assign o_ready  = !w_busy && !r_rd_pend && !r_valid;
    assign w_acc    = i_valid && o_ready;
    assign w_row_ok = (i_row >= 0) && (i_row < HEIGHT);
    assign w_walk_ok = w_we && (w_walk_row >= 0) && (w_walk_row < HEIGHT);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_bx <= i_bx;
            r_by <= i_by_coord;
            r_cx <= i_cx;
            r_cy <= i_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_is_tri        <= (i_opcode == OP_TRI);
        end
    end

    always_comb begin
        w_sx0 = r_ax;
        w_sy0 = r_ay;
        w_sx1 = r_bx;
        w_sy1 = r_by;
        if (r_is_tri) begin
            case (w_esel)
                2'd0: begin
                    w_sx1 = r_cx;
                    w_sy1 = r_cy;
                end
                2'd2: begin
                    w_sx0 = r_bx;
                    w_sy0 = r_by;
                    w_sx1 = r_cx;
                    w_sy1 = r_cy;
                end
                default: begin
                end
            endcase
        end
    end

    tsr_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_x0      (w_sx0),
        .i_y0      (w_sy0),
        .i_x1      (w_sx1),
        .i_y1      (w_sy1),
        .o_sts     (w_sts),
        .o_walk_row(w_walk_row),
        .o_walk_x  (w_walk_x)
    );

    tsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && (i_opcode == OP_TRI || i_opcode == OP_EDGE)),
        .i_is_tri   (i_opcode == OP_TRI),
        .i_side     (i_side_sel),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_edge_sel (w_esel),
        .o_walk_we  (w_we),
        .o_walk_side(w_wside)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == OP_WRITE && w_row_ok) begin
            r_left_mem[i_row[AW-1:0]] <= i_left_x;
        end else if (w_walk_ok && !w_wside) begin
            r_left_mem[w_walk_row[AW-1:0]] <= w_walk_x;
        end
        if (w_acc) begin
            r_rd_l <= r_left_mem[i_row[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == OP_WRITE && w_row_ok) begin
            r_right_mem[i_row[AW-1:0]] <= i_right_x;
        end else if (w_walk_ok && w_wside) begin
            r_right_mem[w_walk_row[AW-1:0]] <= w_walk_x;
        end
        if (w_acc) begin
            r_rd_r <= r_right_mem[i_row[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_rd_pend <= w_acc && i_opcode == OP_READ && w_row_ok;
            if (r_rd_pend) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (w_acc) begin
            r_rd_row <= OUT_ROW_BITS'(i_row);
        end
    end

    assign o_valid     = r_valid;
    assign o_out_row   = r_rd_row;
    assign o_out_left  = r_rd_l;
    assign o_out_right = r_rd_r;
    assign o_out_empty = r_rd_l >= r_rd_r;

endmodule

/* sv/tsr_div.sv */
module tsr_div
    import tsr_pkg::*;
#(
    parameter int NUM_BITS = 29,
    parameter int DEN_BITS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic        [DEN_BITS-1:0] i_den,
    output logic                       o_done,
    output logic signed [NUM_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot, n_quot;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic                r_neg;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS:0]   w_sub;

    always_comb begin
        w_trial = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        w_sub   = w_trial - {1'b0, r_den};
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quot = i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : NUM_BITS'(i_num);
            n_rem  = '0;
            n_cnt  = CNT_BITS'(NUM_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[DEN_BITS]) begin
                n_rem  = w_sub;
                n_quot = {r_quot[NUM_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[NUM_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_den <= i_den;
            r_neg <= i_num[NUM_BITS-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quot) : $signed(r_quot);

endmodule

/* sv/tsr_datapath.sv */
module tsr_datapath
    import tsr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic signed [COORD_BITS-1:0] i_x0,
    input  logic signed [COORD_BITS-1:0] i_y0,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    output t_dp_sts                      o_sts,
    output logic signed [COORD_BITS-1:0] o_walk_row,
    output logic signed [COORD_BITS-1:0] o_walk_x
);

    localparam int DB  = COORD_BITS + 1;
    localparam int NB  = DB + 16;
    localparam int AB  = COORD_BITS + 18;

    logic signed [DB-1:0] w_dx, w_dy;
    logic signed [NB-1:0] w_num;
    logic signed [NB-1:0] w_quot;
    logic                 w_done;
    logic signed [AB-1:0] r_acc;
    logic signed [NB-1:0] r_step;
    logic signed [DB-1:0] r_row;
    logic signed [DB-1:0] r_end;
    logic signed [AB-1:0] w_accq;

    assign w_dx  = DB'(i_x1) - DB'(i_x0);
    assign w_dy  = DB'(i_y1) - DB'(i_y0);
    assign w_num = {w_dx, 16'd0};

    tsr_div #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_dy[DB-1:0]),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_step <= '0;
            r_row  <= '0;
            r_end  <= '0;
        end else if (i_cmd.walk_load) begin
            r_acc  <= AB'($signed({i_x0, 16'd0}));
            r_step <= w_quot;
            r_row  <= DB'(i_y0);
            r_end  <= DB'(i_y1);
        end else if (i_cmd.walk_step) begin
            r_acc <= r_acc + AB'(r_step);
            r_row <= r_row + 1'b1;
        end
    end

    assign w_accq = (r_acc < 0) ? (r_acc + AB'(32'hFFFF)) : r_acc;

    assign o_sts.div_done   = w_done;
    assign o_sts.walk_last  = (r_row + DB'(1)) >= r_end;
    assign o_sts.edge_valid = w_dy > 0;
    assign o_walk_row       = r_row[COORD_BITS-1:0];
    assign o_walk_x         = w_accq[COORD_BITS+15:16];

endmodule

/* sv/tsr_ctrl.sv */
module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_is_tri,
    input  logic       i_side,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic [1:0] o_edge_sel,
    output logic       o_walk_we,
    output logic       o_walk_side
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_edge, n_edge;
    logic       r_tri, r_side;

    always_comb begin
        n_state = r_state;
        n_edge  = r_edge;
        o_cmd   = '0;
        o_walk_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SETUP;
                    n_edge  = 2'd0;
                end
            end
            S_SETUP: begin
                if (i_sts.edge_valid) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (r_tri && r_edge != 2'd2) begin
                    n_edge = r_edge + 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.walk_load = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                o_walk_we = 1'b1;
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    if (r_tri && r_edge != 2'd2) begin
                        n_edge  = r_edge + 1'b1;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_edge  <= '0;
            r_tri   <= 1'b0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
            if (i_start) begin
                r_tri  <= i_is_tri;
                r_side <= i_side;
            end
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_edge_sel  = r_edge;
    assign o_walk_side = (r_tri && r_edge != 2'd0) ? ~r_side : r_side;

endmodule

/* tb/triangle_span_rasterizer_core_tb.sv */
`timescale 1ns / 1ps

module triangle_span_rasterizer_core_tb;
    import tsr_pkg::*;

    localparam int HEIGHT    = 1024;
    localparam int CW        = 12;
    localparam int LIMIT     = 6000000;
    localparam int N_RANDOM  = 124;
    localparam int N_FILL    = 32;

    typedef struct {
        logic [1:0]           opcode;
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
        logic                 side;
        logic signed [CW-1:0] row, left_x, right_x;
        bit                   typed;
        logic [9:0]           e_row;
        logic signed [CW-1:0] e_left, e_right;
        logic                 e_empty;
    } t_request;

    typedef struct {
        logic [9:0]           row;
        logic signed [CW-1:0] left_x, right_x;
        logic                 empty;
    } t_span;

    logic                 i_clk, i_rst_n, i_valid, o_ready, i_ready;
    logic [1:0]           i_opcode;
    logic signed [CW-1:0] i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy;
    logic                 i_side_sel;
    logic signed [CW-1:0] i_row, i_left_x, i_right_x;
    logic                 o_valid, o_out_empty;
    logic [9:0]           o_out_row;
    logic signed [CW-1:0] o_out_left, o_out_right;

    logic signed [CW-1:0] span_left [HEIGHT];
    logic signed [CW-1:0] span_right[HEIGHT];
    bit                   known_l [HEIGHT];
    bit                   known_r [HEIGHT];
    t_span                pending_spans[$];
    int                   fails;
    int                   cycles;
    bit                   calm;

    triangle_span_rasterizer_core #(.HEIGHT(HEIGHT), .COORD_BITS(CW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx),
        .i_by_coord(i_by_coord), .i_cx(i_cx), .i_cy(i_cy), .i_side_sel(i_side_sel),
        .i_row(i_row), .i_left_x(i_left_x), .i_right_x(i_right_x),
        .o_valid(o_valid), .i_ready(i_ready), .o_out_row(o_out_row),
        .o_out_left(o_out_left), .o_out_right(o_out_right), .o_out_empty(o_out_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void trace_edge(int x0, int y0, int x1, int y1, bit side);
        longint dy, dx, stride, acc;
        int r;
        logic signed [CW-1:0] x;
        dy = longint'(y1) - y0;
        dx = longint'(x1) - x0;
        if (dy <= 0) return;
        stride = (dx * 65536) / dy;
        acc = longint'(x0) * 65536;
        for (r = y0; r < y1; r++) begin
            if (r >= 0 && r < HEIGHT) begin
                x = CW'(acc / 65536);
                if (side) begin
                    span_right[r] = x;
                    known_r[r]    = 1'b1;
                end else begin
                    span_left[r] = x;
                    known_l[r]   = 1'b1;
                end
            end
            acc += stride;
        end
    endfunction

    // Applies one request to the span store copy and queues the span a read returns.
    function automatic void apply_request(t_request q);
        t_span s;
        int r;
        r = int'(q.row);
        case (q.opcode)
            OP_WRITE: begin
                if (r >= 0 && r < HEIGHT) begin
                    span_left[r]  = q.left_x;
                    span_right[r] = q.right_x;
                    known_l[r]    = 1'b1;
                    known_r[r]    = 1'b1;
                end
            end
            OP_TRI: begin
                trace_edge(q.ax, q.ay, q.cx, q.cy, q.side);
                trace_edge(q.ax, q.ay, q.bx, q.by, !q.side);
                trace_edge(q.bx, q.by, q.cx, q.cy, !q.side);
            end
            OP_EDGE: trace_edge(q.ax, q.ay, q.bx, q.by, q.side);
            default: begin
                if (r >= 0 && r < HEIGHT) begin
                    if (q.typed) begin
                        s = '{q.e_row, q.e_left, q.e_right, q.e_empty};
                    end else begin
                        s.row     = 10'(r);
                        s.left_x  = span_left[r];
                        s.right_x = span_right[r];
                        s.empty   = (span_left[r] >= span_right[r]);
                    end
                    pending_spans.push_back(s);
                end
            end
        endcase
    endfunction

    task automatic send_request(t_request q);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= q.opcode;
        i_ax       <= q.ax;
        i_ay       <= q.ay;
        i_bx       <= q.bx;
        i_by_coord <= q.by;
        i_cx       <= q.cx;
        i_cy       <= q.cy;
        i_side_sel <= q.side;
        i_row      <= q.row;
        i_left_x   <= q.left_x;
        i_right_x  <= q.right_x;
        do @(posedge i_clk); while (!o_ready);
        apply_request(q);
    endtask

    function automatic t_request make_request(logic [1:0] op, int ax, int ay, int bx, int by,
                                              int cx, int cy, bit side, int row, int lx,
                                              int rx);
        t_request q;
        q = '{op, CW'(ax), CW'(ay), CW'(bx), CW'(by), CW'(cx), CW'(cy), side,
              CW'(row), CW'(lx), CW'(rx), 1'b0, '0, '0, '0, 1'b0};
        return q;
    endfunction

    function automatic int any_coord();
        return int'($signed(CW'($urandom_range(0, 4095))));
    endfunction

    function automatic int near_coord();
        return $urandom_range(0, 9) == 0 ? any_coord() : int'($urandom_range(0, 80)) - 10;
    endfunction

    function automatic t_request random_request();
        t_request q;
        int ya, yb, yc, t, r;
        q = make_request(2'($urandom_range(0, 3)), near_coord(), near_coord(), near_coord(),
                         near_coord(), near_coord(), near_coord(), 1'($urandom_range(0, 1)),
                         near_coord(), any_coord(), any_coord());
        if ($urandom_range(0, 7) == 0) begin
            q = make_request(q.opcode, any_coord(), any_coord(), any_coord(), any_coord(),
                             any_coord(), any_coord(), q.side, any_coord(), q.left_x,
                             q.right_x);
        end else if (q.opcode == OP_TRI && $urandom_range(0, 4) != 0) begin
            // Mostly well-ordered triangles so that edges AC, AB and BC get walked.
            ya = int'(q.ay); yb = int'(q.by); yc = int'(q.cy);
            if (ya > yb) begin t = ya; ya = yb; yb = t; end
            if (yb > yc) begin t = yb; yb = yc; yc = t; end
            if (ya > yb) begin t = ya; ya = yb; yb = t; end
            q.ay = CW'(ya); q.by = CW'(yb); q.cy = CW'(yc);
        end
        if (q.opcode == OP_READ && q.row >= 0 && q.row < HEIGHT) begin
            // A read is moved to a filled row when its own row has not been written.
            r = int'(q.row);
            if (!(known_l[r] && known_r[r])) q.row = CW'($urandom_range(0, N_FILL - 1));
        end
        return q;
    endfunction

    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_span e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_spans.size() == 0) begin
                $error("unexpected span for row %0d", o_out_row);
                fails++;
            end else begin
                e = pending_spans.pop_front();
                if (o_out_row !== e.row) begin
                    $error("out_row expected %0d got %0d", e.row, o_out_row);
                    fails++;
                end
                if (o_out_left !== e.left_x) begin
                    $error("out_left expected %0d got %0d", e.left_x, o_out_left);
                    fails++;
                end
                if (o_out_right !== e.right_x) begin
                    $error("out_right expected %0d got %0d", e.right_x, o_out_right);
                    fails++;
                end
                if (o_out_empty !== e.empty) begin
                    $error("out_empty expected %0d got %0d", e.empty, o_out_empty);
                    fails++;
                end
            end
        end
    end

    initial begin
        t_request directed[$];
        t_request q;
        int i;
        fails = 0; cycles = 0; calm = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_opcode = OP_WRITE;
        i_ax = '0; i_ay = '0; i_bx = '0; i_by_coord = '0; i_cx = '0; i_cy = '0;
        i_side_sel = 1'b0; i_row = '0; i_left_x = '0; i_right_x = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first rows are written so that reads always have a defined entry to return.
        for (i = 0; i < N_FILL; i++)
            send_request(make_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, i, i - 512, 511 - i));

        q = make_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, -2048, 2047);
        directed.push_back(q);
        q = make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        q.typed = 1'b1; q.e_row = 10'd0; q.e_left = -12'sd2048; q.e_right = 12'sd2047;
        q.e_empty = 1'b0;
        directed.push_back(q);
        directed.push_back(make_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 1, 1023, 2047, -2048));
        q = make_request(OP_READ, -1, -1, -1, -1, -1, -1, 1, 1023, -1, -1);
        q.typed = 1'b1; q.e_row = 10'd1023; q.e_left = 12'sd2047; q.e_right = -12'sd2048;
        q.e_empty = 1'b1;
        directed.push_back(q);
        directed.push_back(make_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 1020, 7, 9));
        directed.push_back(make_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, -1, 5, 6));
        directed.push_back(make_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 2047, 5, 6));
        directed.push_back(make_request(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 1024, 5, 6));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, -2048, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 2047, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1024, 0, 0));
        directed.push_back(make_request(OP_EDGE, 3, 10, 40, 10, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(OP_EDGE, 3, 20, 40, 10, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_request(OP_EDGE, 100, -5, -30, 7, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(OP_EDGE, -2048, 1018, 2047, 1030, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_request(OP_TRI, 10, 20, 50, 30, 5, 45, 0, 0, 0, 0));
        directed.push_back(make_request(OP_TRI, 10, 50, 0, 55, 30, 70, 1, 0, 0, 0));
        directed.push_back(make_request(OP_TRI, 0, 60, 8, 60, 4, 60, 0, 0, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 25, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 52, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1020, 0, 0));
        directed.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 0, 0));
        foreach (directed[k]) send_request(directed[k]);

        for (i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 30) calm = 1'b1;
            send_request(random_request());
        end
        i_valid <= 1'b0;

        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (13000) @(posedge i_clk);
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
